@@ src/astigmatic_ctf_evaluator_defines.svh @@
// assertion macros for the astigmatic ctf evaluator checker
// needs clk and rst_n in the scope where a macro is used
`ifndef ASTIGMATIC_CTF_EVALUATOR_DEFINES_SVH
`define ASTIGMATIC_CTF_EVALUATOR_DEFINES_SVH

// same-cycle implication, held off during reset
`define ACF_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define ACF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/acf_pkg.sv @@
// shared types, constants and helpers of the astigmatic ctf evaluator
// no dependencies
package acf_pkg;

    localparam int CORDIC_STEPS = 24;

    // arctangent of 2^-i in turns, scale 2^-32
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;

    typedef enum logic [2:0] {
        REG_CENTER_ROW  = 3'd0,
        REG_FREQ_STEP   = 3'd1,
        REG_DEFOCUS_SUM = 3'd2,
        REG_ASTIG_DIFF  = 3'd3,
        REG_ASTIG_ANGLE = 3'd4,
        REG_WAVELENGTH  = 3'd5,
        REG_SPHER_ABER  = 3'd6,
        REG_AMP_CONTR   = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ACT_SIGN      = 2'd0,
        ACT_VALUE     = 2'd1,
        ACT_MAGNITUDE = 2'd2
    } action_t;

    // one cordic vector as it moves along the row of cells
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               flip;
    } cordic_vec_t;

    // fold a phase in turns into the right half plane and build the seed vector
    function automatic cordic_vec_t rot_seed(input logic [31:0] phase);
        logic [31:0]  lifted;
        logic [31:0]  folded;
        cordic_vec_t  v;
        lifted = phase + 32'h4000_0000;
        folded = lifted[31] ? (phase ^ 32'h8000_0000) : phase;
        v.x    = CORDIC_START;
        v.y    = '0;
        v.z    = 34'(signed'(folded));
        v.flip = lifted[31];
        return v;
    endfunction

endpackage

@@ src/acf_mul64.sv @@
// pipelined 64 x 64 unsigned multiplier, full 128-bit product
// four 32 x 32 partial products, then one summing stage; uses no package
module acf_mul64 (
    input  logic          clk,
    input  logic          en,
    input  logic [63:0]   a,
    input  logic [63:0]   b,
    output logic [127:0]  prod
);
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [63:0]  p00_next, p01_next, p10_next, p11_next;
    logic [127:0] prod_reg, prod_next;

    always_comb
    begin
        p00_next  = a[31:0]  * b[31:0];
        p01_next  = a[31:0]  * b[63:32];
        p10_next  = a[63:32] * b[31:0];
        p11_next  = a[63:32] * b[63:32];
        prod_next = {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                  + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg  <= p00_next;
            p01_reg  <= p01_next;
            p10_reg  <= p10_next;
            p11_reg  <= p11_next;
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;
endmodule

@@ src/acf_cordic_cell.sv @@
// one cordic micro-rotation cell, vectoring or rotating
// depends on acf_pkg for the vector type and the arctangent table
module acf_cordic_cell (
    input  logic                clk,
    input  logic                en,
    input  logic                vec_mode,
    input  logic [4:0]          step,
    input  acf_pkg::cordic_vec_t vec_in,
    output acf_pkg::cordic_vec_t vec_out
);
    import acf_pkg::*;

    logic signed [33:0] xs, ys, angle;
    logic               down;
    cordic_vec_t        vec_reg, vec_next;

    always_comb
    begin
        xs    = vec_in.x >>> step;
        ys    = vec_in.y >>> step;
        angle = signed'({2'b00, ATAN_TURNS[step]});
        // vectoring drives y to zero, rotating drives z to zero
        down  = vec_mode ? (vec_in.y <= 0) : (vec_in.z >= 0);
        vec_next.flip = vec_in.flip;
        if (down)
        begin
            vec_next.x = vec_in.x - ys;
            vec_next.y = vec_in.y + xs;
            vec_next.z = vec_in.z - angle;
        end
        else
        begin
            vec_next.x = vec_in.x + ys;
            vec_next.y = vec_in.y - xs;
            vec_next.z = vec_in.z + angle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vec_out = vec_reg;
endmodule

@@ src/acf_isqrt_cell.sv @@
// one step of the digit-by-digit integer square root
// no package needed; step selects the trial bit
module acf_isqrt_cell (
    input  logic        clk,
    input  logic [4:0]  step,
    input  logic [63:0] n_in,
    input  logic [63:0] res_in,
    output logic [63:0] n_out,
    output logic [63:0] res_out
);
    logic [63:0] bitv, trial;
    logic [63:0] n_reg, n_next, res_reg, res_next;

    always_comb
    begin
        bitv  = 64'd1 << (6'd62 - {step, 1'b0});
        trial = res_in + bitv;
        if (n_in >= trial)
        begin
            n_next   = n_in - trial;
            res_next = (res_in >> 1) + bitv;
        end
        else
        begin
            n_next   = n_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        res_reg <= res_next;
    end

    assign n_out   = n_reg;
    assign res_out = res_reg;
endmodule

@@ src/astigmatic_ctf_evaluator.sv @@
// top level of the astigmatic contrast transfer function evaluator
// uses acf_pkg, acf_mul64, acf_cordic_cell and acf_isqrt_cell
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  item     | item_valid, item_stall, action, col, row | in
//  result   | result_valid, result_stall, ctf_value    | out
//  config   | cfg_wen, cfg_index, cfg_data             | in
//
// one request per clock while no result is stalled
// a request passes through the three 24-cell cordic rows plus the multiplier stages
// a stalled result freezes the whole item pipeline, and item_stall follows at once
// reset loads the configuration defaults and clears the valid line; derived coefficients
// settle after a register write, ahead of the stages that read them
module astigmatic_ctf_evaluator #(
    parameter int MAX_SIZE = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  action,
    input  logic [11:0] col,
    input  logic [11:0] row,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] ctf_value,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import acf_pkg::*;

    localparam int          LAST     = 81;     // stage of the output register
    localparam int          R2_TAP   = 47;     // stage where the frequency path starts
    localparam logic [13:0] LIMIT    = 14'(MAX_SIZE - 1);
    localparam logic [32:0] ANG_OFS  = 33'd3019898880;   // 45 * 2^26, keeps angle positive
    localparam logic [63:0] RECIP_45 = 64'd6254999482459;  // floor(2^48 / 45)

    // ---------------- configuration registers ----------------
    logic [11:0]        center_row_reg;
    logic [31:0]        freq_step_reg;
    logic signed [31:0] defocus_sum_reg;
    logic signed [31:0] astig_diff_reg;
    logic signed [31:0] astig_angle_reg;
    logic [31:0]        wavelength_reg;
    logic [31:0]        spher_reg;
    logic [15:0]        amp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_row_reg  <= 12'd128;
            freq_step_reg   <= '0;
            defocus_sum_reg <= '0;
            astig_diff_reg  <= '0;
            astig_angle_reg <= '0;
            wavelength_reg  <= '0;
            spher_reg       <= '0;
            amp_reg         <= 16'd2294;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_CENTER_ROW:  center_row_reg  <= cfg_data[11:0];
                REG_FREQ_STEP:   freq_step_reg   <= cfg_data;
                REG_DEFOCUS_SUM: defocus_sum_reg <= cfg_data;
                REG_ASTIG_DIFF:  astig_diff_reg  <= cfg_data;
                REG_ASTIG_ANGLE: astig_angle_reg <= cfg_data;
                REG_WAVELENGTH:  wavelength_reg  <= cfg_data;
                REG_SPHER_ABER:  spher_reg       <= cfg_data;
                REG_AMP_CONTR:   amp_reg         <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // ---------------- free-running coefficient pipeline ----------------
    // these only follow the registers, so they run whether or not items stall
    logic [127:0] fs2_prod, w2_prod, l3_prod, cs_prod, k1_prod, k2_prod, q_prod;
    logic [63:0]  fs2, w2, l3, cs25, k1, k2;

    acf_mul64 u_mul_fs2 (.clk(clk), .en(1'b1), .a({32'd0, freq_step_reg}),
                         .b({32'd0, freq_step_reg}), .prod(fs2_prod));
    acf_mul64 u_mul_w2  (.clk(clk), .en(1'b1), .a({32'd0, wavelength_reg}),
                         .b({32'd0, wavelength_reg}), .prod(w2_prod));
    acf_mul64 u_mul_l3  (.clk(clk), .en(1'b1), .a(w2),
                         .b({32'd0, wavelength_reg}), .prod(l3_prod));
    acf_mul64 u_mul_cs  (.clk(clk), .en(1'b1), .a({32'd0, spher_reg}),
                         .b(64'd2500000), .prod(cs_prod));
    acf_mul64 u_mul_k1  (.clk(clk), .en(1'b1), .a(cs25), .b(l3), .prod(k1_prod));
    acf_mul64 u_mul_k2  (.clk(clk), .en(1'b1), .a({32'd0, wavelength_reg}),
                         .b(64'd5000), .prod(k2_prod));

    assign fs2  = fs2_prod[63:0];       // freq_step squared, scale 2^-64
    assign w2   = w2_prod[63:0];
    assign l3   = l3_prod[95:32];       // wavelength cubed, scale 2^-64
    assign cs25 = cs_prod[63:0];
    assign k1   = k1_prod[123:60];      // spherical term coefficient, scale 2^-32
    assign k2   = k2_prod[63:0];        // defocus term coefficient, scale 2^-32

    // twice the axis angle in turns: floor(angle * 1024 / 45) by reciprocal
    logic [32:0] ang_off;
    logic [63:0] xq;
    logic [37:0] qa;
    logic [43:0] q_rem;
    logic [31:0] q_reg, q_next;

    assign ang_off = 33'(astig_angle_reg) + ANG_OFS;
    assign xq      = {21'd0, ang_off, 10'd0};

    acf_mul64 u_mul_q (.clk(clk), .en(1'b1), .a(xq), .b(RECIP_45), .prod(q_prod));

    always_comb
    begin
        qa     = q_prod[85:48];
        // estimate is at most one short; the offset vanishes modulo one turn
        q_rem  = {1'b0, xq[42:0]} - (44'(qa) * 44'd45);
        q_next = (q_rem >= 44'd45) ? (qa[31:0] + 32'd1) : qa[31:0];
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    // amplitude terms: a = amp, b = sqrt(1 - amp^2) through a row of root cells
    logic [15:0] amp_sat;
    logic [31:0] amp_sq;
    logic [63:0] sq_seed_reg, sq_seed_next;
    logic [63:0] sq_n   [0:CORDIC_STEPS + 8];
    logic [63:0] sq_res [0:CORDIC_STEPS + 8];
    logic [30:0] a_val, b_val;

    always_comb
    begin
        amp_sat      = (amp_reg > 16'd32768) ? 16'd32768 : amp_reg;
        amp_sq       = amp_sat * amp_sat;
        sq_seed_next = {2'b00, (32'h4000_0000 - amp_sq), 30'd0};
    end

    always_ff @(posedge clk)
    begin
        sq_seed_reg <= sq_seed_next;
    end

    assign sq_n[0]   = sq_seed_reg;
    assign sq_res[0] = '0;

    for (genvar g = 0; g < 32; g++)
    begin : g_root
        acf_isqrt_cell u_cell (
            .clk     (clk),
            .step    (5'(g)),
            .n_in    (sq_n[g]),
            .res_in  (sq_res[g]),
            .n_out   (sq_n[g + 1]),
            .res_out (sq_res[g + 1])
        );
    end

    assign a_val = {amp_sat, 15'd0};
    assign b_val = sq_res[32][30:0];

    // ---------------- item pipeline ----------------
    logic en, accept;

    assign en         = !(result_valid && result_stall);
    assign item_stall = !en;
    assign accept     = item_valid && en;

    // valid, action and squared radius travel beside the cordic rows
    logic        vld_reg [0:LAST];
    logic [1:0]  act_reg [0:LAST - 1];
    logic [25:0] r2_reg  [1:R2_TAP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= accept;
            for (int k = 1; k <= LAST; k++)
            begin
                vld_reg[k] <= vld_reg[k - 1];
            end
        end
    end

    // index clamps and row offset from the centre row
    logic [11:0]        col_c, row_c, cr_c;
    logic [11:0]        dx_reg;
    logic signed [12:0] dy_reg, dy_next;
    logic [11:0]        dy_abs;
    logic [25:0]        r2_next;

    always_comb
    begin
        col_c   = ({2'b00, col} > LIMIT) ? LIMIT[11:0] : col;
        row_c   = ({2'b00, row} > LIMIT) ? LIMIT[11:0] : row;
        cr_c    = ({2'b00, center_row_reg} > LIMIT) ? LIMIT[11:0] : center_row_reg;
        dy_next = signed'({1'b0, row_c}) - signed'({1'b0, cr_c});
        // magnitude of the row offset always fits 12 bits
        dy_abs  = (dy_reg < 0) ? 12'(-dy_reg) : dy_reg[11:0];
        r2_next = (26'(dx_reg) * 26'(dx_reg)) + (26'(dy_abs) * 26'(dy_abs));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= col_c;
            dy_reg     <= dy_next;
            act_reg[0] <= action;
            for (int k = 1; k < LAST; k++)
            begin
                act_reg[k] <= act_reg[k - 1];
            end
            r2_reg[1] <= r2_next;
            for (int k = 2; k <= R2_TAP; k++)
            begin
                r2_reg[k] <= r2_reg[k - 1];
            end
        end
    end

    // azimuth: vectoring row, x = dx * 2^16, y = dy * 2^16
    cordic_vec_t vv [0:CORDIC_STEPS];

    always_comb
    begin
        vv[0].x    = 34'({dx_reg, 16'd0});
        vv[0].y    = 34'(signed'({dy_reg, 16'd0}));
        vv[0].z    = '0;
        vv[0].flip = 1'b0;
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_vec
        acf_cordic_cell u_cell (
            .clk(clk), .en(en), .vec_mode(1'b1), .step(5'(g)),
            .vec_in(vv[g]), .vec_out(vv[g + 1])
        );
    end

    // angle 2 * (axis - azimuth) in turns, then cosine by a rotating row
    cordic_vec_t seed1_reg, seed1_next;
    cordic_vec_t vr1 [0:CORDIC_STEPS];

    assign seed1_next = rot_seed(q_reg - {vv[CORDIC_STEPS].z[30:0], 1'b0});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seed1_reg <= seed1_next;
        end
    end

    assign vr1[0] = seed1_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_rot1
        acf_cordic_cell u_cell (
            .clk(clk), .en(en), .vec_mode(1'b0), .step(5'(g)),
            .vec_in(vr1[g]), .vec_out(vr1[g + 1])
        );
    end

    // local defocus, scale 2^-25
    logic signed [33:0] cos_ang;
    logic signed [65:0] adc_reg, adc_next;
    logic signed [35:0] dfq_reg, dfq_next;

    always_comb
    begin
        cos_ang  = vr1[CORDIC_STEPS].flip ? -vr1[CORDIC_STEPS].x : vr1[CORDIC_STEPS].x;
        adc_next = astig_diff_reg * cos_ang;
        dfq_next = 36'(defocus_sum_reg) + 36'(adc_reg >>> 29);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adc_reg <= adc_next;
            dfq_reg <= dfq_next;
        end
    end

    // spatial frequency path, started late so it meets the defocus
    logic [127:0] s_prod, ss_prod, ks_prod, t1_prod, t2_prod;
    logic [63:0]  s_val, ss_val, ks_val;

    acf_mul64 u_mul_s  (.clk(clk), .en(en), .a({38'd0, r2_reg[R2_TAP]}), .b(fs2),
                        .prod(s_prod));
    assign s_val  = s_prod[95:32];      // squared frequency, scale 2^-32

    acf_mul64 u_mul_ss (.clk(clk), .en(en), .a(s_val), .b(s_val), .prod(ss_prod));
    acf_mul64 u_mul_ks (.clk(clk), .en(en), .a(k2), .b(s_val), .prod(ks_prod));
    assign ss_val = ss_prod[95:32];
    assign ks_val = ks_prod[95:32];

    acf_mul64 u_mul_t1 (.clk(clk), .en(en), .a(k1), .b(ss_val), .prod(t1_prod));
    acf_mul64 u_mul_t2 (.clk(clk), .en(en), .a(64'(dfq_reg)), .b(ks_val),
                        .prod(t2_prod));

    // phase is minus both terms, modulo one turn
    cordic_vec_t seed2_reg, seed2_next;
    cordic_vec_t vr2 [0:CORDIC_STEPS];

    assign seed2_next = rot_seed(32'd0 - (t1_prod[63:32] + t2_prod[56:25]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seed2_reg <= seed2_next;
        end
    end

    assign vr2[0] = seed2_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_rot2
        acf_cordic_cell u_cell (
            .clk(clk), .en(en), .vec_mode(1'b0), .step(5'(g)),
            .vec_in(vr2[g]), .vec_out(vr2[g + 1])
        );
    end

    // b * sin + a * cos, clamp and action
    logic signed [33:0] gc, gs;
    logic signed [65:0] pa_reg, pa_next, pb_reg, pb_next;
    logic signed [66:0] sum_w;
    logic signed [33:0] v_reg, v_next, vc;
    logic [31:0]        res_reg, res_next;

    always_comb
    begin
        gc      = vr2[CORDIC_STEPS].flip ? -vr2[CORDIC_STEPS].x : vr2[CORDIC_STEPS].x;
        gs      = vr2[CORDIC_STEPS].flip ? -vr2[CORDIC_STEPS].y : vr2[CORDIC_STEPS].y;
        pa_next = signed'({1'b0, a_val}) * gc;
        pb_next = signed'({1'b0, b_val}) * gs;
        sum_w   = 67'(pa_reg) + 67'(pb_reg);
        v_next  = 34'(sum_w >>> 30);
        if (v_reg > ONE_Q30)
        begin
            vc = ONE_Q30;
        end
        else if (v_reg < -ONE_Q30)
        begin
            vc = -ONE_Q30;
        end
        else
        begin
            vc = v_reg;
        end
        case (act_reg[LAST - 1])
            ACT_SIGN:      res_next = (vc > 0) ? ONE_Q30[31:0] : 32'(-ONE_Q30);
            ACT_MAGNITUDE: res_next = (vc < 0) ? 32'(-vc) : vc[31:0];
            default:       res_next = vc[31:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            v_reg   <= v_next;
            res_reg <= res_next;
        end
    end

    assign result_valid = vld_reg[LAST];
    assign ctf_value    = res_reg;
endmodule

@@ src/acf_checker.sv @@
// port-level checker for the astigmatic ctf evaluator, bound to the top level
// depends on astigmatic_ctf_evaluator_defines.svh
`include "astigmatic_ctf_evaluator_defines.svh"

module acf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [31:0] ctf_value
);
    // a stalled result stays put
    `ACF_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(ctf_value), "result changed under stall")
    // value never leaves minus one to one
    `ACF_ASSERT_IMPLY(a_range, result_valid, ($signed(ctf_value) <= 32'sd1073741824) && ($signed(ctf_value) >= -32'sd1073741824), "result out of range")
    // requests are held back only by a stalled result
    `ACF_ASSERT_IMPLY(a_back, item_stall, result_valid && result_stall, "item stalled without cause")
    // nothing comes out of reset
    `ACF_ASSERT_IMPLY(a_rst, $rose(rst_n), !result_valid, "result valid straight after reset")
endmodule

bind astigmatic_ctf_evaluator acf_checker u_acf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ctf_value    (ctf_value)
);

@@ tb/astigmatic_ctf_evaluator_test.sv @@
// self-checking testbench of the astigmatic ctf evaluator: fixed-point ctf prediction,
// randomised pixels and register settings under varying handshake pressure
// depends on acf_pkg and astigmatic_ctf_evaluator
`timescale 1ns / 100ps

module astigmatic_ctf_evaluator_test;
    import acf_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  action;
    logic [11:0] col;
    logic [11:0] row;
    logic        result_valid;
    logic        result_stall;
    logic [31:0] ctf_value;
    logic        cfg_wen;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    astigmatic_ctf_evaluator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .col          (col),
        .row          (row),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ctf_value    (ctf_value),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // shadow copy of the optics registers, as the block holds them
    logic [11:0] sh_center_row;
    logic [31:0] sh_freq_step;
    logic [31:0] sh_defocus_sum;
    logic [31:0] sh_astig_diff;
    logic [31:0] sh_astig_angle;
    logic [31:0] sh_wavelength;
    logic [31:0] sh_spher_aber;
    logic [15:0] sh_amp_contr;

    logic [31:0] ctf_pending[$];   // predicted ctf values, oldest first
    int          failures;
    int          pixels_sent;
    int          results_seen;
    int          settings_used;
    int          gap_pct;          // chance in a hundred that the sender idles
    int          stall_pct;        // chance in a hundred that the receiver stalls

    // clock, 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // generous overall limit
    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------------
    // fixed-point ctf prediction
    // ---------------------------------------------------------------------

    // floor(a*b / 2^s) kept to 64 bits
    function automatic longint unsigned mul_shift(longint unsigned a, longint unsigned b,
                                                   int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    // azimuth of (dx, dy) in turns, scale 2^-32, by vectoring cordic
    function automatic logic [31:0] azimuth_turns(longint dx, longint dy);
        longint            x;
        longint            y;
        longint            xs;
        longint            ys;
        logic [31:0]       z;
        x = dx * 65536;
        y = dy * 65536;
        z = '0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURNS[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURNS[i];
            end
        end
        return z;
    endfunction

    // cosine and sine of a phase in turns, scale 2^-30, by rotating cordic
    task automatic rotate_phase(input logic [31:0] phase, output longint c, output longint s);
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        logic [31:0] lifted;
        logic        flip;
        lifted = phase + 32'h4000_0000;
        flip   = lifted[31];
        if (flip)
            phase = phase ^ 32'h8000_0000;
        x = 652032874;
        y = 0;
        z = longint'(signed'(phase));
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TURNS[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TURNS[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic predict_ctf(input logic [1:0] act, input logic [11:0] c_idx,
                               input logic [11:0] r_idx, output logic [31:0] ctf);
        longint          dx;
        longint          dy;
        longint unsigned r2;
        longint unsigned s_sq;
        longint unsigned lam3;
        longint unsigned k_cs;
        longint unsigned k_df;
        longint unsigned tmp;
        logic [31:0]     t_cs;
        logic [31:0]     t_df;
        logic [31:0]     phi;
        longint          ang2;
        longint          q;
        longint          c;
        longint          sn;
        longint          gc;
        longint          gs;
        longint          dfq;
        longint unsigned amp;
        longint          a;
        longint          b;
        longint          v;
        // indices are 12 bits wide, so they never pass the image size limit
        dx   = longint'(c_idx);
        dy   = longint'(r_idx) - longint'(sh_center_row);
        r2   = longint'(dx * dx + dy * dy);
        s_sq = mul_shift(r2, {32'd0, sh_freq_step} * {32'd0, sh_freq_step}, 32);
        lam3 = mul_shift({32'd0, sh_wavelength} * {32'd0, sh_wavelength},
                         {32'd0, sh_wavelength}, 32);
        k_cs = mul_shift({32'd0, sh_spher_aber} * 64'd2500000, lam3, 60);
        k_df = {32'd0, sh_wavelength} * 64'd5000;
        tmp  = (k_cs * mul_shift(s_sq, s_sq, 32)) >> 32;
        t_cs = tmp[31:0];

        // twice the astigmatism angle in turns, floored
        ang2 = longint'(signed'(sh_astig_angle)) * 1024;
        q    = (ang2 >= 0) ? ang2 / 45 : -((-ang2 + 44) / 45);
        phi  = q[31:0] - 2 * azimuth_turns(dx, dy);
        rotate_phase(phi, c, sn);
        dfq  = longint'(signed'(sh_defocus_sum))
             + ((longint'(signed'(sh_astig_diff)) * c) >>> 29);
        tmp  = (longint'(unsigned'(dfq)) * mul_shift(k_df, s_sq, 32)) >> 25;
        t_df = tmp[31:0];
        rotate_phase(32'd0 - (t_cs + t_df), gc, gs);

        // amplitude contrast saturates at one
        amp = (sh_amp_contr > 16'd32768) ? 64'd32768 : {48'd0, sh_amp_contr};
        a   = longint'(amp << 15);
        b   = longint'(floor_sqrt((64'd1073741824 - amp * amp) << 30));
        v   = (b * gs + a * gc) >>> 30;
        if (v > 1073741824)
            v = 1073741824;
        if (v < -1073741824)
            v = -1073741824;
        if (act == ACT_SIGN)
            v = (v > 0) ? 1073741824 : -1073741824;
        else if (act == ACT_MAGNITUDE && v < 0)
            v = -v;
        // a code of three behaves as the plain signed value
        ctf = v[31:0];
    endtask

    // ---------------------------------------------------------------------
    // result side: stall generator and checker
    // ---------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    // inputs only move at the rising edge, so the falling edge sees settled values
    always @(negedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (ctf_pending.size() == 0)
            begin
                failures++;
                $error("unexpected result: ctf_value actual %0d", $signed(ctf_value));
            end
            else
            begin
                logic [31:0] want;
                want = ctf_pending.pop_front();
                if (want !== ctf_value)
                begin
                    failures++;
                    $error("ctf_value mismatch: expected %0d actual %0d",
                           $signed(want), $signed(ctf_value));
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------------

    // one pixel request; returns just after the edge that takes it
    task automatic send_pixel(input logic [1:0] act, input logic [11:0] c_idx,
                              input logic [11:0] r_idx);
        logic [31:0] want;
        while ($urandom_range(99) < gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        action     <= act;
        col        <= c_idx;
        row        <= r_idx;
        predict_ctf(act, c_idx, r_idx, want);
        @(negedge clk);
        while (item_stall)
            @(negedge clk);
        @(posedge clk);
        ctf_pending.push_back(want);
        pixels_sent++;
    endtask

    task automatic send_random_pixel();
        logic [11:0] r_idx;
        // mostly rows near the centre, where real spectra live, plus the full span
        if ($urandom_range(3) == 0)
            r_idx = $urandom_range(4095);
        else
            r_idx = sh_center_row + 12'($urandom_range(512)) - 12'd256;
        send_pixel(2'($urandom_range(3)), ($urandom_range(3) == 0) ? 12'($urandom_range(4095))
                   : 12'($urandom_range(300)), r_idx);
    endtask

    // let the pipeline empty, then the fixed latency, so registers change while idle
    task automatic drain();
        item_valid <= 1'b0;
        while (ctf_pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // drives one register write; the caller drops the write enable afterwards
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_CENTER_ROW:  sh_center_row  = data[11:0];
            REG_FREQ_STEP:   sh_freq_step   = data;
            REG_DEFOCUS_SUM: sh_defocus_sum = data;
            REG_ASTIG_DIFF:  sh_astig_diff  = data;
            REG_ASTIG_ANGLE: sh_astig_angle = data;
            REG_WAVELENGTH:  sh_wavelength  = data;
            REG_SPHER_ABER:  sh_spher_aber  = data;
            REG_AMP_CONTR:   sh_amp_contr   = data[15:0];
            default: ;
        endcase
    endtask

    // full register set, then time for the derived coefficients to settle
    task automatic load_optics(input logic [31:0] crow, input logic [31:0] fstep,
                               input logic [31:0] dsum, input logic [31:0] adiff,
                               input logic [31:0] aang, input logic [31:0] lam,
                               input logic [31:0] cs, input logic [31:0] ac);
        write_reg(REG_CENTER_ROW, crow);
        write_reg(REG_FREQ_STEP, fstep);
        write_reg(REG_DEFOCUS_SUM, dsum);
        write_reg(REG_ASTIG_DIFF, adiff);
        write_reg(REG_ASTIG_ANGLE, aang);
        write_reg(REG_WAVELENGTH, lam);
        write_reg(REG_SPHER_ABER, cs);
        write_reg(REG_AMP_CONTR, ac);
        cfg_wen <= 1'b0;
        repeat (40) @(posedge clk);
        settings_used++;
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // reset values: zero frequency step, so every pixel gives the amplitude term
    task automatic test_reset_values();
        send_pixel(ACT_VALUE, 12'd0, 12'd128);
        send_pixel(ACT_SIGN, 12'd4095, 12'd4095);
        send_pixel(ACT_MAGNITUDE, 12'd17, 12'd0);
        drain();
    endtask

    // field extremes, every action, zero frequency and saturating registers
    task automatic test_corner_cases();
        // typical 300 kV optics on a 256 pixel box
        load_optics(32'd128, 32'h0100_0000, 32'd67108864, 32'd3355443,
                    32'd47185920, 32'd84590000, 32'd724775731, 32'd2294);
        send_pixel(ACT_VALUE, 12'd0, 12'd128);        // zero frequency
        send_pixel(ACT_SIGN, 12'd0, 12'd128);
        send_pixel(ACT_MAGNITUDE, 12'd40, 12'd100);
        send_pixel(2'd3, 12'd40, 12'd100);            // undefined action code
        send_pixel(ACT_SIGN, 12'd4095, 12'd4095);
        send_pixel(ACT_VALUE, 12'd4095, 12'd0);
        send_pixel(ACT_MAGNITUDE, 12'd2048, 12'd2048);
        send_pixel(ACT_VALUE, 12'd0, 12'd0);
        drain();
        // register maxima: amplitude above one saturates, centre on the last row
        load_optics(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF);
        send_pixel(ACT_VALUE, 12'd4095, 12'd4095);
        send_pixel(ACT_SIGN, 12'd1, 12'd0);
        send_pixel(ACT_MAGNITUDE, 12'd2048, 12'd4094);
        send_pixel(ACT_VALUE, 12'd0, 12'd4095);
        drain();
        // register minima and pure phase contrast
        load_optics(32'd0, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'd0, 32'd0, 32'd0);
        send_pixel(ACT_SIGN, 12'd0, 12'd0);
        send_pixel(ACT_VALUE, 12'd4095, 12'd4095);
        drain();
        load_optics(32'd2048, 32'h0200_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'd84590000, 32'd724775731, 32'd32768);
        send_pixel(ACT_VALUE, 12'd2048, 12'd2048);
        send_pixel(ACT_MAGNITUDE, 12'd300, 12'd1900);
        send_pixel(ACT_SIGN, 12'd5, 12'd2050);
        drain();
    endtask

    // random optics, mostly realistic, some anything at all
    task automatic test_random_optics(input int pixels);
        logic [31:0] crow;
        if ($urandom_range(3) == 0)
            load_optics($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
        else
        begin
            crow = 32'($urandom_range(8, 11));
            crow = 32'd1 << crow;
            load_optics(crow >> 1, 32'($urandom_range(32'h0040_0000, 32'h0400_0000)),
                        32'($urandom_range(0, 200_000_000)),
                        32'($signed($urandom_range(0, 20_000_000)) - 10_000_000),
                        $urandom, 32'($urandom_range(40_000_000, 160_000_000)),
                        32'($urandom_range(0, 1_500_000_000)),
                        32'($urandom_range(0, 8000)));
        end
        repeat (pixels) send_random_pixel();
        drain();
    endtask

    // handshake pressure phases
    task automatic test_pressure(input int gap, input int stall, input int settings);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (settings) test_random_optics(48);
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        action         = '0;
        col            = '0;
        row            = '0;
        cfg_wen        = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        failures       = 0;
        pixels_sent    = 0;
        results_seen   = 0;
        settings_used  = 0;
        gap_pct        = 0;
        stall_pct      = 0;
        sh_center_row  = 12'd128;
        sh_freq_step   = '0;
        sh_defocus_sum = '0;
        sh_astig_diff  = '0;
        sh_astig_angle = '0;
        sh_wavelength  = '0;
        sh_spher_aber  = '0;
        sh_amp_contr   = 16'd2294;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_corner_cases();
        test_pressure(0, 0, 6);
        test_pressure(61, 0, 6);
        test_pressure(0, 61, 6);
        test_pressure(29, 29, 6);

        drain();
        $display("covered %0d pixel requests, %0d results, %0d optics settings",
                 pixels_sent, results_seen, settings_used);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
